// ===== hw/rtl/pacc_pkg.sv =====
// ----------------------------------------------------------------------------
// pacc_pkg: shared types and constants of the priority accumulator
// Entry count, pick count, priority constants and the beat and
// controller/datapath structs.
// ----------------------------------------------------------------------------
package pacc_pkg;

    localparam int NUM_ENTRIES = 64;
    localparam int PICKS       = 31;
    localparam int NPICKS      = (PICKS < NUM_ENTRIES) ? PICKS : NUM_ENTRIES;
    localparam int IDX_W       = (NUM_ENTRIES > 1) ? $clog2(NUM_ENTRIES) : 1;
    localparam int PK_W        = (NPICKS > 1) ? $clog2(NPICKS) : 1;
    localparam int ACC_W       = 48;
    localparam int PRIO_W      = 20;
    localparam int TW_W        = 16;
    localparam int PROD_W      = PRIO_W + TW_W;

    localparam logic [PRIO_W-1:0] PRIO_BASE     = 20'd1;
    localparam logic [PRIO_W-1:0] PRIO_PLAYER   = 20'd1000000;
    localparam logic [PRIO_W-1:0] PRIO_INTERACT = 20'd100;
    localparam logic [TW_W-1:0]   TW_RESET      = 16'd1092;
    localparam logic [ACC_W-1:0]  ACC_MAX       = {ACC_W{1'b1}};

    localparam logic FUNC_SET  = 1'b0;
    localparam logic FUNC_TICK = 1'b1;

    typedef struct packed {
        logic       func;
        logic [5:0] entry;
        logic       interacting;
    } item_t;

    typedef struct packed {
        logic [5:0] picked;
        logic       last;
    } result_t;

    typedef struct packed {
        logic             set_en;
        logic             clr_list;
        logic             rd_en;
        logic [IDX_W-1:0] rd_addr;
        logic             emit;
        logic             emit_last;
    } ctl_cmd_t;

    typedef struct packed {
        logic pipe_busy;
    } ctl_sts_t;

endpackage

// ===== hw/rtl/pacc_ctrl.sv =====
// ----------------------------------------------------------------------------
// pacc_ctrl: sequencer of the priority accumulator
// Walks the entries on a tick, waits for the pipeline to drain, then
// issues one pick per cycle.
// ----------------------------------------------------------------------------
module pacc_ctrl
    import pacc_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     start,
    input  item_t    item,
    input  ctl_sts_t sts,
    output ctl_cmd_t cmd,
    output logic     busy
);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_WALK  = 2'd1;
    localparam logic [1:0] ST_DRAIN = 2'd2;
    localparam logic [1:0] ST_EMIT  = 2'd3;

    logic [1:0]       state_reg, state_next;
    logic [IDX_W-1:0] addr_reg, addr_next;
    logic [PK_W-1:0]  pk_reg, pk_next;
    logic             accept;

    assign busy   = (state_reg != ST_IDLE);
    assign accept = start && !busy;

    // Next state and command decode
    always_comb
    begin
        state_next    = state_reg;
        addr_next     = addr_reg;
        pk_next       = pk_reg;
        cmd           = '0;
        cmd.rd_addr   = addr_reg;
        cmd.emit_last = (pk_reg == PK_W'(NPICKS - 1));
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (item.func == FUNC_TICK)
                    begin
                        cmd.clr_list = 1'b1;
                        addr_next    = '0;
                        state_next   = ST_WALK;
                    end
                    else
                    begin
                        cmd.set_en = 1'b1;
                    end
                end
            end
            ST_WALK:
            begin
                cmd.rd_en = 1'b1;
                addr_next = addr_reg + 1'b1;
                if (addr_reg == IDX_W'(NUM_ENTRIES - 1))
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                pk_next = '0;
                if (!sts.pipe_busy)
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                cmd.emit = 1'b1;
                pk_next  = pk_reg + 1'b1;
                if (cmd.emit_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Hold state and counters
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            addr_reg  <= '0;
            pk_reg    <= '0;
        end
        else
        begin
            state_reg <= state_next;
            addr_reg  <= addr_next;
            pk_reg    <= pk_next;
        end
    end

endmodule

// ===== hw/rtl/pacc_datapath.sv =====
// ----------------------------------------------------------------------------
// pacc_datapath: accumulator memory, update pipeline and pick list
// Three stages: read and product, add and saturate with write-back,
// sorted insertion into the pick list. The list shifts out on emit.
// ----------------------------------------------------------------------------
module pacc_datapath
    import pacc_pkg::*;
(
    input  logic            clk,
    input  logic            rst_n,
    input  item_t           item,
    input  ctl_cmd_t        cmd,
    input  logic            cfg_we,
    input  logic [TW_W-1:0] cfg_wdata,
    output ctl_sts_t        sts,
    output logic            result_valid,
    output result_t         result
);

    logic [ACC_W-1:0]       mem [NUM_ENTRIES];
    logic [NUM_ENTRIES-1:0] mem_vld_reg;
    logic [NUM_ENTRIES-1:0] flag_reg;
    logic [TW_W-1:0]        tw_reg;

    logic [ACC_W-1:0]       rd_data_reg;
    logic                   rd_vld_reg;
    logic [PROD_W-1:0]      prod_reg;
    logic [IDX_W-1:0]       s1_idx_reg;
    logic                   s1_vld_reg;
    logic [ACC_W-1:0]       s2_val_reg;
    logic [IDX_W-1:0]       s2_idx_reg;
    logic                   s2_vld_reg;

    logic                   cell_vld_reg [NPICKS];
    logic [ACC_W-1:0]       cell_val_reg [NPICKS];
    logic [IDX_W-1:0]       cell_idx_reg [NPICKS];
    logic                   gt [NPICKS];

    logic [PRIO_W-1:0]      prio;
    logic [ACC_W:0]         sum;
    logic [ACC_W-1:0]       sat;
    logic                   wr_en;
    logic [IDX_W-1:0]       wr_addr;
    logic [ACC_W-1:0]       wr_data;
    result_t                res_reg;
    logic                   res_vld_reg;

    assign sts.pipe_busy = s1_vld_reg || s2_vld_reg;
    assign result_valid  = res_vld_reg;
    assign result        = res_reg;

    // Priority of the entry being read
    always_comb
    begin
        prio = PRIO_BASE;
        if (cmd.rd_addr == '0)
        begin
            prio = prio + PRIO_PLAYER;
        end
        if (flag_reg[cmd.rd_addr])
        begin
            prio = prio + PRIO_INTERACT;
        end
    end

    // Add and saturate
    always_comb
    begin
        sum = {1'b0, (rd_vld_reg ? rd_data_reg : {ACC_W{1'b0}})} + (ACC_W + 1)'(prod_reg);
        sat = sum[ACC_W] ? ACC_MAX : sum[ACC_W-1:0];
    end

    // Write port: update during the walk, clear during emit
    always_comb
    begin
        wr_en   = s1_vld_reg || cmd.emit;
        wr_addr = cmd.emit ? cell_idx_reg[0] : s1_idx_reg;
        wr_data = cmd.emit ? '0 : sat;
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[cmd.rd_addr];
    end

    // Hold valid bits, flags, weight and pipeline control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mem_vld_reg <= '0;
            flag_reg    <= '0;
            tw_reg      <= TW_RESET;
            rd_vld_reg  <= 1'b0;
            s1_vld_reg  <= 1'b0;
            s2_vld_reg  <= 1'b0;
            res_vld_reg <= 1'b0;
        end
        else
        begin
            if (wr_en)
            begin
                mem_vld_reg[wr_addr] <= 1'b1;
            end
            if (cmd.set_en && (32'(item.entry) < NUM_ENTRIES))
            begin
                flag_reg[IDX_W'(item.entry)] <= item.interacting;
            end
            if (cfg_we)
            begin
                tw_reg <= cfg_wdata;
            end
            rd_vld_reg  <= mem_vld_reg[cmd.rd_addr];
            s1_vld_reg  <= cmd.rd_en;
            s2_vld_reg  <= s1_vld_reg;
            res_vld_reg <= cmd.emit;
        end
    end

    // Advance pipeline payload
    always_ff @(posedge clk)
    begin
        prod_reg   <= PROD_W'(tw_reg) * PROD_W'(prio);
        s1_idx_reg <= cmd.rd_addr;
        s2_val_reg <= sat;
        s2_idx_reg <= s1_idx_reg;
        res_reg.picked <= 6'(cell_idx_reg[0]);
        res_reg.last   <= cmd.emit_last;
    end

    // Cells the new value beats: empty cells always lose, equals keep place
    always_comb
    begin
        for (int k = 0; k < NPICKS; k++)
        begin
            gt[k] = !cell_vld_reg[k] || (s2_val_reg > cell_val_reg[k]);
        end
    end

    // Sorted pick list: insert, shift out, or clear
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < NPICKS; k++)
            begin
                cell_vld_reg[k] <= 1'b0;
            end
        end
        else if (cmd.clr_list)
        begin
            for (int k = 0; k < NPICKS; k++)
            begin
                cell_vld_reg[k] <= 1'b0;
            end
        end
        else if (cmd.emit)
        begin
            for (int k = 0; k < NPICKS - 1; k++)
            begin
                cell_vld_reg[k] <= cell_vld_reg[k+1];
            end
            cell_vld_reg[NPICKS-1] <= 1'b0;
        end
        else if (s2_vld_reg)
        begin
            for (int k = 0; k < NPICKS; k++)
            begin
                if (gt[k])
                begin
                    cell_vld_reg[k] <= (k == 0) ? 1'b1 :
                        (gt[(k == 0) ? 0 : k-1] ? cell_vld_reg[(k == 0) ? 0 : k-1] : 1'b1);
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            for (int k = 0; k < NPICKS - 1; k++)
            begin
                cell_val_reg[k] <= cell_val_reg[k+1];
                cell_idx_reg[k] <= cell_idx_reg[k+1];
            end
        end
        else if (s2_vld_reg && !cmd.clr_list)
        begin
            for (int k = 0; k < NPICKS; k++)
            begin
                if (gt[k])
                begin
                    if ((k == 0) || !gt[(k == 0) ? 0 : k-1])
                    begin
                        cell_val_reg[k] <= s2_val_reg;
                        cell_idx_reg[k] <= s2_idx_reg;
                    end
                    else
                    begin
                        cell_val_reg[k] <= cell_val_reg[(k == 0) ? 0 : k-1];
                        cell_idx_reg[k] <= cell_idx_reg[(k == 0) ? 0 : k-1];
                    end
                end
            end
        end
    end

endmodule

// ===== hw/rtl/priority_accumulator_top_k.sv =====
// ----------------------------------------------------------------------------
// priority_accumulator_top_k: priority accumulator with top-K selection
// Per-entry saturating accumulators; each tick emits the highest entries.
// ----------------------------------------------------------------------------
// Usage:
//   Input beat: item is taken at a rising edge with start high and busy
//   low. A set beat stores an entry's interacting flag and gives no
//   result. A tick beat walks all NUM_ENTRIES accumulators through a
//   three-stage update pipeline (one entry per cycle, one read and one
//   write memory port), then emits NPICKS picks, one per cycle, highest
//   first. busy stays high until the final pick has been issued.
//   Output beat: result_valid marks each pick for one cycle, result.last
//   flags the final one. The receiver cannot stall; results are never held.
//   Configuration: cfg_we writes tick_weight from cfg_wdata; the user must
//   write it only while idle, which the block itself does not enforce.
//   Reset: accumulators read as zero (per-entry valid bits), flags clear,
//   tick_weight returns to 1092; the block is ready at once.
// ----------------------------------------------------------------------------
module priority_accumulator_top_k
    import pacc_pkg::*;
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            start,
    output logic            busy,
    input  item_t           item,
    output logic            result_valid,
    output result_t         result,
    input  logic            cfg_we,
    input  logic [TW_W-1:0] cfg_wdata
);

    ctl_cmd_t cmd;
    ctl_sts_t sts;

    pacc_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .item  (item),
        .sts   (sts),
        .cmd   (cmd),
        .busy  (busy)
    );

    pacc_datapath u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .item         (item),
        .cmd          (cmd),
        .cfg_we       (cfg_we),
        .cfg_wdata    (cfg_wdata),
        .sts          (sts),
        .result_valid (result_valid),
        .result       (result)
    );

endmodule

// ===== test/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench: regression for priority_accumulator_top_k
// Drives set and tick beats with random gaps, predicts the pick order of
// every tick from a local model of the accumulators and checks each pick.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module testbench;
    import pacc_pkg::*;

    localparam int WATCHDOG_LIMIT = 20000;
    localparam int DRAIN_CYCLES   = NUM_ENTRIES + NPICKS + 20;

    logic            clk;
    logic            rst_n;
    logic            start;
    logic            busy;
    item_t           item;
    logic            result_valid;
    result_t         result;
    logic            cfg_we;
    logic [TW_W-1:0] cfg_wdata;

    // model state
    logic [ACC_W-1:0] model_acc [NUM_ENTRIES];
    logic             model_flag [NUM_ENTRIES];
    logic [TW_W-1:0]  model_weight;
    result_t          pending_picks [$];

    int errors;
    int picks_seen;
    int ticks_sent;
    int sets_sent;
    int idle_cycles;

    priority_accumulator_top_k dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .item         (item),
        .result_valid (result_valid),
        .result       (result),
        .cfg_we       (cfg_we),
        .cfg_wdata    (cfg_wdata)
    );

    // clock: 4 ns period
    always
    begin
        clk = 1'b0;
        #2;
        clk = 1'b1;
        #2;
    end

    // work out the picks of one beat and queue them
    task automatic predict_beat(input item_t it);
        logic [ACC_W:0]   sum;
        logic [PROD_W-1:0] prod;
        logic [PRIO_W-1:0] prio;
        logic              taken [NUM_ENTRIES];
        int                chosen [NPICKS];
        int                best;
        result_t           r;
        if (it.func == FUNC_SET)
        begin
            if (int'(it.entry) < NUM_ENTRIES)
                model_flag[it.entry] = it.interacting;
            return;
        end
        for (int i = 0; i < NUM_ENTRIES; i++)
        begin
            prio = PRIO_BASE;
            if (i == 0)
                prio = prio + PRIO_PLAYER;
            if (model_flag[i])
                prio = prio + PRIO_INTERACT;
            prod = PROD_W'(model_weight) * PROD_W'(prio);
            sum = {1'b0, model_acc[i]} + (ACC_W+1)'(prod);
            model_acc[i] = sum[ACC_W] ? ACC_MAX : sum[ACC_W-1:0];
            taken[i] = 1'b0;
        end
        for (int k = 0; k < NPICKS; k++)
        begin
            best = -1;
            for (int i = 0; i < NUM_ENTRIES; i++)
                if (!taken[i] && (best < 0 || model_acc[i] > model_acc[best]))
                    best = i;
            taken[best] = 1'b1;
            chosen[k] = best;
            r.picked = 6'(best);
            r.last = (k == NPICKS - 1);
            pending_picks.push_back(r);
        end
        for (int k = 0; k < NPICKS; k++)
            model_acc[chosen[k]] = '0;
    endtask

    // random gap length, mostly short, now and then long
    function automatic int gap_length();
        if ($urandom_range(0, 9) == 0)
            return int'($urandom_range(20, 150));
        return int'($urandom_range(0, 3));
    endfunction

    // send one beat and wait for it to be taken; start stays high after the
    // accepting edge until the next beat, a gap or a drain takes it over
    task automatic send_beat(input logic func, input logic [5:0] entry,
                             input logic interacting, input bit gaps);
        item_t it;
        int    n;
        it.func = func;
        it.entry = entry;
        it.interacting = interacting;
        n = gaps ? gap_length() : 0;
        if (n > 0)
        begin
            start <= 1'b0;
            item  <= item_t'(8'($urandom));
            repeat (n) @(posedge clk);
        end
        start <= 1'b1;
        item  <= it;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        predict_beat(it);
        if (func == FUNC_TICK)
            ticks_sent++;
        else
            sets_sent++;
    endtask

    // hold off until every pick has arrived, then let the pipeline drain
    task automatic wait_drained();
        start <= 1'b0;
        item  <= item_t'(8'($urandom));
        while (pending_picks.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_weight(input logic [TW_W-1:0] w);
        wait_drained();
        cfg_we    <= 1'b1;
        cfg_wdata <= w;
        @(posedge clk);
        model_weight = w;
        cfg_we    <= 1'b0;
        cfg_wdata <= TW_W'($urandom);
    endtask

    // check each pick against the oldest expectation
    always @(posedge clk)
    begin
        result_t want;
        if (rst_n && result_valid)
        begin
            picks_seen++;
            if (pending_picks.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected pick %0d last %0b", $time,
                         result.picked, result.last);
            end
            else
            begin
                want = pending_picks.pop_front();
                if (result.picked !== want.picked)
                begin
                    errors++;
                    $display("%0t: picked expected %0d actual %0d", $time,
                             want.picked, result.picked);
                end
                if (result.last !== want.last)
                begin
                    errors++;
                    $display("%0t: last expected %0b actual %0b", $time,
                             want.last, result.last);
                end
            end
        end
    end

    // watchdog: count cycles with no beat moving in either direction
    always @(posedge clk)
    begin
        if ((start && !busy) || result_valid || cfg_we)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("priority_accumulator_top_k regression: fail");
            $finish;
        end
    end

    // reset-state ticks: all zero accumulators with ties to the lower index
    task automatic test_reset_ticks();
        send_beat(FUNC_TICK, 6'd0, 1'b0, 1'b0);
        send_beat(FUNC_TICK, 6'd63, 1'b1, 1'b0);
        send_beat(FUNC_TICK, 6'd17, 1'b0, 1'b1);
    endtask

    // flags at the extremes of entry, then ticks that pick them up
    task automatic test_flags();
        send_beat(FUNC_SET, 6'd63, 1'b1, 1'b0);
        send_beat(FUNC_SET, 6'd0, 1'b1, 1'b0);
        send_beat(FUNC_SET, 6'd42, 1'b1, 1'b1);
        send_beat(FUNC_SET, 6'd21, 1'b1, 1'b0);
        send_beat(FUNC_TICK, 6'd0, 1'b0, 1'b0);
        send_beat(FUNC_SET, 6'd42, 1'b0, 1'b0);
        send_beat(FUNC_TICK, 6'd42, 1'b1, 1'b1);
        send_beat(FUNC_TICK, 6'd0, 1'b0, 1'b0);
    endtask

    // weight extremes: zero leaves the accumulators unchanged, full scale gives the largest products
    task automatic test_weights();
        write_weight(16'd0);
        send_beat(FUNC_TICK, 6'd0, 1'b0, 1'b0);
        send_beat(FUNC_TICK, 6'd0, 1'b0, 1'b0);
        write_weight(16'hFFFF);
        for (int i = 0; i < 6; i++)
            send_beat(FUNC_TICK, 6'(i), 1'b0, 1'b0);
        write_weight(16'd1);
        send_beat(FUNC_TICK, 6'd0, 1'b0, 1'b0);
    endtask

    // random mix of set and tick beats across several weights
    task automatic test_random();
        logic [TW_W-1:0] w;
        for (int n = 0; n < 200; n++)
        begin
            if (n % 50 == 25)
            begin
                case ($urandom_range(0, 3))
                    0: w = 16'd0;
                    1: w = 16'hFFFF;
                    2: w = TW_RESET;
                    default: w = TW_W'($urandom);
                endcase
                write_weight(w);
            end
            if (n == 100)
                wait_drained();
            send_beat(($urandom_range(0, 3) == 0) ? FUNC_TICK : FUNC_SET,
                      6'($urandom), 1'($urandom), 1'b1);
        end
    endtask

    initial
    begin
        errors = 0;
        picks_seen = 0;
        ticks_sent = 0;
        sets_sent = 0;
        idle_cycles = 0;
        rst_n = 1'b0;
        start = 1'b0;
        item = '0;
        cfg_we = 1'b0;
        cfg_wdata = '0;
        model_weight = TW_RESET;
        for (int i = 0; i < NUM_ENTRIES; i++)
        begin
            model_acc[i] = '0;
            model_flag[i] = 1'b0;
        end
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_ticks();
        test_flags();
        test_weights();
        test_random();

        wait_drained();
        $display("Covered %0d set beats and %0d ticks, %0d picks checked,",
                 sets_sent, ticks_sent, picks_seen);
        $display("with zero, reset, random and full-scale tick weights.");
        if (errors == 0)
            $display("priority_accumulator_top_k regression: pass");
        else
            $display("priority_accumulator_top_k regression: fail");
        $finish;
    end

endmodule
